// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// File: hdl/mtss_pkg.sv
// ----------------------------------------------------------------------------
// mtss_pkg
// Shared types and constants of the two-stream merge unit.
// ----------------------------------------------------------------------------
package mtss_pkg;

  localparam int SAMPLE_W          = 32;
  localparam int BUFFER_DEPTH_DEF  = 16;

  // One accepted input word as handed from the front to the back.
  typedef struct packed {
    logic                       is_b;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       done;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       from_b;
    logic                       complete;
    logic                       drop;
  } result_t;

endpackage

// File: hdl/mtss_front_queue.sv
// ----------------------------------------------------------------------------
// mtss_front_queue
// Input acceptor: two-entry command queue between the port and the merge back.
// ----------------------------------------------------------------------------
module mtss_front_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mtss_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output mtss_pkg::cmd_t cmd
);
  import mtss_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/mtss_merge_back.sv
// ----------------------------------------------------------------------------
// mtss_merge_back
// Merge engine: checks each word, stores it or reports it as dropped, and emits merged results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtss_merge_back #(
  parameter int BUFFER_DEPTH = mtss_pkg::BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  mtss_pkg::cmd_t    cmd_in,
  output logic              out_valid,
  input  logic              out_ready,
  output mtss_pkg::result_t out_res
);
  import mtss_pkg::*;

  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_CLASS, S_READ, S_EMIT} state_t;

  state_t                     state;
  cmd_t                       cmd;
  logic [IDX_W-1:0]           head_a, tail_a, head_b, tail_b;
  logic [CNT_W-1:0]           fill_a, fill_b;
  logic                       ended_a, ended_b;
  logic signed [SAMPLE_W-1:0] mem_a [BUFFER_DEPTH];
  logic signed [SAMPLE_W-1:0] mem_b [BUFFER_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_a, rd_b;

  logic out_free, drop_hit, a_ne, b_ne, both, a_le, tail_a_go, sel_a, sel_b, emit;
  logic complete;
  logic out_load;

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == S_IDLE);

  assign drop_hit = cmd.is_b ? (ended_b || fill_b == CNT_W'(BUFFER_DEPTH))
                             : (ended_a || fill_a == CNT_W'(BUFFER_DEPTH));

  assign a_ne      = (fill_a != '0);
  assign b_ne      = (fill_b != '0);
  assign both      = a_ne && b_ne;
  assign a_le      = (rd_a <= rd_b);
  assign tail_a_go = a_ne && ended_b;
  assign sel_a     = both ? a_le  : tail_a_go;
  assign sel_b     = both ? !a_le : (!tail_a_go && b_ne && ended_a);
  assign emit      = sel_a || sel_b;
  assign complete  = ended_a && ended_b &&
                     (sel_a ? (fill_a == CNT_W'(1) && !b_ne)
                            : (fill_b == CNT_W'(1) && !a_ne));

  // Load the output register with a drop report or a merged word.
  assign out_load  = out_free &&
                     ((state == S_CLASS && drop_hit) || (state == S_EMIT && emit));

  // Buffers: one write at the tail, one registered read at the head.
  always_ff @(posedge clk) begin
    if (state == S_CLASS && !drop_hit && !cmd.is_b) begin
      mem_a[tail_a] <= cmd.sample;
    end
    rd_a <= mem_a[head_a];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLASS && !drop_hit && cmd.is_b) begin
      mem_b[tail_b] <= cmd.sample;
    end
    rd_b <= mem_b[head_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_a    <= '0;
      tail_a    <= '0;
      head_b    <= '0;
      tail_b    <= '0;
      fill_a    <= '0;
      fill_b    <= '0;
      ended_a   <= 1'b0;
      ended_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd   <= cmd_in;
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (drop_hit) begin
            // report the discarded word, nothing else this round
            if (out_free) begin
              out_res.value    <= cmd.sample;
              out_res.from_b   <= cmd.is_b;
              out_res.complete <= 1'b0;
              out_res.drop     <= 1'b1;
              state            <= S_IDLE;
            end
          end else begin
            if (cmd.is_b) begin
              tail_b <= inc_idx(tail_b);
              fill_b <= fill_b + CNT_W'(1);
              if (cmd.done) ended_b <= 1'b1;
            end else begin
              tail_a <= inc_idx(tail_a);
              fill_a <= fill_a + CNT_W'(1);
              if (cmd.done) ended_a <= 1'b1;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!emit) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_res.value    <= sel_a ? rd_a : rd_b;
            out_res.from_b   <= sel_b;
            out_res.complete <= complete;
            out_res.drop     <= 1'b0;
            if (complete) begin
              head_a  <= '0;
              tail_a  <= '0;
              head_b  <= '0;
              tail_b  <= '0;
              fill_a  <= '0;
              fill_b  <= '0;
              ended_a <= 1'b0;
              ended_b <= 1'b0;
              state   <= S_IDLE;
            end else begin
              if (sel_a) begin
                head_a <= inc_idx(head_a);
                fill_a <= fill_a - CNT_W'(1);
              end else begin
                head_b <= inc_idx(head_b);
                fill_b <= fill_b - CNT_W'(1);
              end
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_fill_a_range, clk, rst, fill_a > CNT_W'(BUFFER_DEPTH))
  `ASSERT_NEVER(a_fill_b_range, clk, rst, fill_b > CNT_W'(BUFFER_DEPTH))
  `ASSERT_NEVER(a_idle_both_held, clk, rst, state == S_IDLE && a_ne && b_ne)
  `ASSERT_NEVER(a_idle_both_ended, clk, rst, state == S_IDLE && ended_a && ended_b)
  `ASSERT_AT(a_drop_not_last, clk, rst, out_valid && out_res.drop |-> !out_res.complete)

endmodule

// File: hdl/merge_two_sorted_streams_unit.sv
// ----------------------------------------------------------------------------
// merge_two_sorted_streams_unit
// Two-way merge of two ascending streams of signed 16.16 values.
// ----------------------------------------------------------------------------
//   channel | dir | tdata            | tuser                       | tlast
//   s_*     | in  | [31:0] sample    | [0] from_stream_b           | stream_done
//   m_*     | out | [31:0] merged    | [0] came_from_b, [1] dropped | merge_complete
//
// Sequence: the front queue registers each word; the merge engine latches it
//   (S_IDLE), stores it (S_CLASS) and reads the buffer heads (S_READ) before
//   the first result of a word; each further result follows a buffer read at
//   the head, then compare and pop (S_EMIT), once the output register is free.
//   A dropped word is reported from S_CLASS; a word that releases nothing goes
//   back to S_IDLE from S_EMIT. The registered read port sets result spacing.
// Reset: rst is synchronous; heads, fill counts, end flags and queues clear.
//   Buffer contents are not cleared and need no clearing pass.
// Stalls: a two-word front queue takes input while the engine works, until full;
//   the output register holds a result while m_tready is low.
// ----------------------------------------------------------------------------
module merge_two_sorted_streams_unit #(
  parameter int BUFFER_DEPTH = mtss_pkg::BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic [0:0]  s_tuser,   // [0] from_stream_b
  input  logic        s_tlast,   // stream_done
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] merged_value
  output logic [1:0]  m_tuser,   // [0] came_from_b, [1] dropped
  output logic        m_tlast    // merge_complete
);
  import mtss_pkg::*;

  cmd_t    in_cmd;
  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_ready;
  result_t res;

  // Pack the input word for the queue.
  assign in_cmd.is_b   = s_tuser[0];
  assign in_cmd.sample = s_tdata;
  assign in_cmd.done   = s_tlast;

  mtss_front_queue u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mtss_merge_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_in    (cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Unpack the result word onto the master side.
  assign m_tdata = res.value;
  assign m_tuser = {res.drop, res.from_b};
  assign m_tlast = res.complete;

endmodule

// File: sim/merge_two_sorted_streams_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_two_sorted_streams_unit_tb
// Drives pairs of ascending streams into the merge unit and checks every
// merged word, drop report and end-of-merge flag. A scoreboard keeps its own
// copy of both stream buffers and predicts the words from each accepted input.
// ----------------------------------------------------------------------------
module merge_two_sorted_streams_unit_tb;
  import mtss_pkg::*;

  class merge_scoreboard;
    logic signed [SAMPLE_W-1:0] fifo_a [BUFFER_DEPTH_DEF];
    logic signed [SAMPLE_W-1:0] fifo_b [BUFFER_DEPTH_DEF];
    int unsigned                rd_a, rd_b, cnt_a, cnt_b;
    bit                         closed_a, closed_b;
    result_t                    expected_q [$];
    int unsigned                mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    // Rewind both streams for the next merge.
    function void clear();
      rd_a     = 0;
      rd_b     = 0;
      cnt_a    = 0;
      cnt_b    = 0;
      closed_a = 1'b0;
      closed_b = 1'b0;
    endfunction

    function bit merge_idle();
      return cnt_a == 0 && cnt_b == 0 && !closed_a && !closed_b;
    endfunction

    // Take one accepted input word and queue every word it releases.
    function void note_input(bit is_b, logic signed [SAMPLE_W-1:0] smp, bit last);
      result_t                    r;
      bit                         src;
      logic signed [SAMPLE_W-1:0] val;
      if (is_b ? (closed_b || cnt_b >= BUFFER_DEPTH_DEF)
               : (closed_a || cnt_a >= BUFFER_DEPTH_DEF)) begin
        // Full buffer or ended stream: drop the word, end flag included.
        r.value    = smp;
        r.from_b   = is_b;
        r.complete = 1'b0;
        r.drop     = 1'b1;
        expected_q.push_back(r);
        return;
      end
      if (is_b) begin
        fifo_b[(rd_b + cnt_b) % BUFFER_DEPTH_DEF] = smp;
        cnt_b++;
        if (last) closed_b = 1'b1;
      end else begin
        fifo_a[(rd_a + cnt_a) % BUFFER_DEPTH_DEF] = smp;
        cnt_a++;
        if (last) closed_a = 1'b1;
      end
      while (1'b1) begin
        if (cnt_a > 0 && cnt_b > 0) begin
          src = (fifo_a[rd_a] <= fifo_b[rd_b]) ? 1'b0 : 1'b1;  // A wins ties
        end else if (cnt_a > 0 && closed_b) begin
          src = 1'b0;
        end else if (cnt_b > 0 && closed_a) begin
          src = 1'b1;
        end else begin
          break;
        end
        if (src) begin
          val  = fifo_b[rd_b];
          rd_b = (rd_b + 1) % BUFFER_DEPTH_DEF;
          cnt_b--;
        end else begin
          val  = fifo_a[rd_a];
          rd_a = (rd_a + 1) % BUFFER_DEPTH_DEF;
          cnt_a--;
        end
        r.value    = val;
        r.from_b   = src;
        r.drop     = 1'b0;
        r.complete = closed_a && closed_b && cnt_a == 0 && cnt_b == 0;
        expected_q.push_back(r);
        if (r.complete) begin
          clear();
          break;
        end
      end
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: exp %h b=%0b l=%0b d=%0b, got %h b=%0b l=%0b d=%0b",
                 what, want.value, want.from_b, want.complete, want.drop,
                 got.value, got.from_b, got.complete, got.drop);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value || got.from_b !== want.from_b ||
          got.complete !== want.complete || got.drop !== want.drop)
        report("wrong word", want, got);
    endfunction
  endclass

  localparam int                   WATCHDOG_LIMIT = 2000;
  localparam int                   TAIL_CYCLES    = 40;
  localparam int                   RANDOM_WORDS   = 120;
  localparam bit                   STREAM_A       = 1'b0;
  localparam bit                   STREAM_B       = 1'b1;
  localparam logic signed [31:0]   MIN_Q          = 32'sh8000_0000;
  localparam logic signed [31:0]   MAX_Q          = 32'sh7FFF_FFFF;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] sample
  logic [0:0]  s_tuser  = '0;   // [0] from_stream_b
  logic        s_tlast  = 1'b0; // stream_done
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [31:0] merged_value
  logic [1:0]  m_tuser;         // [0] came_from_b, [1] dropped
  logic        m_tlast;         // merge_complete

  merge_scoreboard sb;
  result_t         seen_word;
  int unsigned     words_sent  = 0;
  int unsigned     out_hold    = 0;
  int unsigned     idle_cycles = 0;
  bit              in_burst    = 1'b0;
  bit              out_burst   = 1'b0;

  merge_two_sorted_streams_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Advance an ascending run by a random step, saturate at the top of range.
  function automatic logic [31:0] step_up(inout longint run, input int unsigned sh);
    run = run + longint'($urandom_range(0, 1 << sh));
    if (run > 64'sd2147483647) run = 64'sd2147483647;
    return run[31:0];
  endfunction

  // Offer one word, hold it until the handshake, then note it.
  task automatic send_word(bit is_b, logic [31:0] smp, bit last);
    int unsigned gap;
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= is_b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_input(is_b, smp, last);
    words_sent++;
  endtask

  // One merge: two ascending runs, interleaved, with optional noise; then
  // close whatever stream is still open so the next merge starts clean.
  task automatic run_merge();
    int unsigned len_a, len_b, sent_a, sent_b, sh;
    longint      base, run_a, run_b;
    bit          a_first, noisy, pick_b;
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    a_first   = ($urandom_range(0, 7) == 0);
    noisy     = ($urandom_range(0, 5) == 0);
    len_a     = a_first ? $urandom_range(10, 20) : $urandom_range(1, 8);
    len_b     = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) len_b = $urandom_range(9, 16);
    base = longint'($signed($urandom())) >>> $urandom_range(0, 20);
    if ($urandom_range(0, 9) == 0) base = -64'sd2147483648;
    sh     = $urandom_range(0, 24);
    run_a  = base + $urandom_range(0, 255);
    run_b  = base + $urandom_range(0, 255);
    sent_a = 0;
    sent_b = 0;
    while (sent_a < len_a || sent_b < len_b) begin
      if (sent_a == len_a) pick_b = 1'b1;
      else if (sent_b == len_b) pick_b = 1'b0;
      else pick_b = a_first ? 1'b0 : 1'($urandom_range(0, 1));
      if (pick_b) begin
        sent_b++;
        send_word(STREAM_B, step_up(run_b, sh), sent_b == len_b);
      end else begin
        sent_a++;
        send_word(STREAM_A, step_up(run_a, sh), sent_a == len_a);
      end
      // Broken sequence: an out-of-order value, maybe an early end.
      if (noisy && $urandom_range(0, 5) == 0)
        send_word(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
    end
    while (!sb.merge_idle()) begin
      if (!sb.closed_a && sb.cnt_a < BUFFER_DEPTH_DEF)
        send_word(STREAM_A, $urandom(), 1'b1);
      else
        send_word(STREAM_B, $urandom(), 1'b1);
    end
  endtask

  // Take result words and stall the output at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_word.value    = m_tdata;
        seen_word.from_b   = m_tuser[0];
        seen_word.drop     = m_tuser[1];
        seen_word.complete = m_tlast;
        sb.check_result(seen_word);
      end
      if (out_hold > 0) begin
        out_hold--;
        m_tready <= 1'b0;
      end else if (!out_burst && $urandom_range(0, 3) == 0) begin
        out_hold = pick_gap();
        if (out_hold > 0) out_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("merge_two_sorted_streams_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned directed_words;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes and ties: A wins a tie at the bottom and at the top of range.
    send_word(STREAM_A, MIN_Q, 1'b0);
    send_word(STREAM_B, MIN_Q, 1'b0);
    send_word(STREAM_A, 32'h0000_0000, 1'b0);
    send_word(STREAM_B, MAX_Q, 1'b1);
    send_word(STREAM_A, MAX_Q, 1'b1);

    // Word for a stream that already ended gets dropped.
    send_word(STREAM_A, 32'h0005_0000, 1'b1);
    send_word(STREAM_A, 32'h0007_0000, 1'b0);
    send_word(STREAM_B, 32'hFFFD_0000, 1'b1);

    // Fill A with no B data, overflow once, then release both.
    for (int i = 0; i < BUFFER_DEPTH_DEF; i++)
      send_word(STREAM_A, i << 16, 1'b0);
    send_word(STREAM_A, 32'h00FF_0000, 1'b1);
    send_word(STREAM_B, MAX_Q, 1'b1);
    send_word(STREAM_A, BUFFER_DEPTH_DEF << 16, 1'b1);
    directed_words = words_sent;

    while (words_sent < directed_words + RANDOM_WORDS)
      run_merge();
    s_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("merge_two_sorted_streams_unit: match");
    else
      $display("merge_two_sorted_streams_unit: mismatch");
    $finish;
  end

endmodule
